>>> rtl/crcfr_pkg.sv
// Package for the CRC-16 framed packet receiver: constants, types, CRC byte update.
`default_nettype none

package crcfr_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CrcW  = 16;
  localparam int unsigned PosW  = 9;
  localparam int unsigned AddrW = 3;
  localparam int unsigned RegW  = 32;

  localparam logic [DataW-1:0] StartMark = 8'h02;
  localparam logic [DataW-1:0] StopMark  = 8'h03;
  localparam logic [CrcW-1:0]  PolyReset = 16'h1021;

  // Register indexes (word address bits of paddr)
  localparam logic [AddrW-3:0] RegCrcPoly = 1'b0;

  // Byte positions inside a frame
  localparam logic [PosW-1:0] PosIdle   = 9'd0;
  localparam logic [PosW-1:0] PosLength = 9'd1;
  localparam logic [PosW-1:0] PosFirst  = 9'd2;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             last;
    logic             good;
  } out_item_t;

  // One byte into an MSB-first CRC-16, no reflection
  function automatic logic [CrcW-1:0] crc_byte(input logic [CrcW-1:0]  crc,
                                               input logic [DataW-1:0] b,
                                               input logic [CrcW-1:0]  poly);
    logic [CrcW-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < DataW; k++) begin
      if (c[CrcW-1]) begin
        c = {c[CrcW-2:0], 1'b0} ^ poly;
      end else begin
        c = {c[CrcW-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/crc16_framed_packet_receiver_core.sv
// Top level: framed packet receiver with per-byte CRC-16 check and APB polynomial register.
`default_nettype none

// Takes one received byte per cycle on the slave stream while s_axis_tready
// is high and parses frames of start byte 2, length L (1..255), L payload
// bytes, a big-endian CRC-16 (MSB-first, init 0, no final xor) and stop byte
// 3. Each payload byte comes out as an item with tlast low; a verdict item
// (tdata zero, tlast high, tuser = frame good) closes the frame after a
// failing CRC low byte or after the stop byte. A zero length drops the frame
// silently. The parse and the byte-wide CRC update are done on the accepted
// byte, and the result is registered in the output skid. A two-entry output
// skid keeps s_axis_tready high while its spare entry is empty; it drops only
// when both entries hold results. The polynomial (reset 0x1021) sits at byte
// address 0 and applies from the next payload byte.
module crc16_framed_packet_receiver_core (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  // slave stream
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire  [crcfr_pkg::DataW-1:0] s_axis_tdata_i,   // [7:0] rx_byte
  // master stream
  output logic                        m_axis_tvalid_o,
  input  wire                         m_axis_tready_i,
  output logic [crcfr_pkg::DataW-1:0] m_axis_tdata_o,   // [7:0] data_byte
  output logic                        m_axis_tlast_o,   // frame_end
  output logic                        m_axis_tuser_o,   // [0] frame_good
  // APB configuration
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [crcfr_pkg::AddrW-1:0] paddr,
  input  wire  [crcfr_pkg::RegW-1:0]  pwdata,
  output logic [crcfr_pkg::RegW-1:0]  prdata,
  output logic                        pready
);
  import crcfr_pkg::*;

  logic [CrcW-1:0]  poly_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [DataW-1:0] len_q, len_d;
  logic [CrcW-1:0]  rx_crc_q, rx_crc_d;
  logic [CrcW-1:0]  crc_q, crc_d;

  logic             accept;
  logic             emit;
  out_item_t        res;
  out_item_t        out_item;
  logic [PosW-1:0]  pos_crc_hi;
  logic [CrcW-1:0]  rx_crc_full;
  logic [DataW-1:0] b;
  logic             reg_hit;

  // APB
  assign pready  = 1'b1;
  assign reg_hit = (paddr[AddrW-1:2] == RegCrcPoly);
  assign prdata  = reg_hit ? {{(RegW-CrcW){1'b0}}, poly_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poly_q <= PolyReset;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      poly_q <= pwdata[CrcW-1:0];
    end
  end

  // frame parser
  assign b           = s_axis_tdata_i;
  assign accept      = s_axis_tvalid_i & s_axis_tready_o;
  assign pos_crc_hi  = {1'b0, len_q} + PosFirst;
  assign rx_crc_full = {rx_crc_q[CrcW-1:DataW], b};

  always_comb begin
    pos_d    = pos_q;
    len_d    = len_q;
    rx_crc_d = rx_crc_q;
    crc_d    = crc_q;
    if (pos_q == PosIdle) begin
      if (b == StartMark) begin
        pos_d    = PosLength;
        crc_d    = '0;
        rx_crc_d = '0;
      end
    end else if (pos_q == PosLength) begin
      len_d = b;
      pos_d = (b == '0) ? PosIdle : PosFirst;
    end else if (pos_q < pos_crc_hi) begin
      crc_d = crc_byte(crc_q, b, poly_q);
      pos_d = pos_q + 9'd1;
    end else if (pos_q == pos_crc_hi) begin
      rx_crc_d = {b, 8'h00};
      pos_d    = pos_q + 9'd1;
    end else if (pos_q == pos_crc_hi + 9'd1) begin
      rx_crc_d = rx_crc_full;
      pos_d    = (rx_crc_full != crc_q) ? PosIdle : pos_q + 9'd1;
    end else begin
      pos_d = PosIdle;
    end
  end

  always_comb begin
    emit = 1'b0;
    res  = '{data: '0, last: 1'b0, good: 1'b0};
    if (pos_q == PosIdle || pos_q == PosLength) begin
      emit = 1'b0;
    end else if (pos_q < pos_crc_hi) begin
      emit     = 1'b1;
      res.data = b;
    end else if (pos_q == pos_crc_hi) begin
      emit = 1'b0;
    end else if (pos_q == pos_crc_hi + 9'd1) begin
      emit     = (rx_crc_full != crc_q);
      res.last = 1'b1;
    end else begin
      emit     = 1'b1;
      res.last = 1'b1;
      res.good = (b == StopMark);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= PosIdle;
      len_q    <= '0;
      rx_crc_q <= '0;
      crc_q    <= '0;
    end else if (accept) begin
      pos_q    <= pos_d;
      len_q    <= len_d;
      rx_crc_q <= rx_crc_d;
      crc_q    <= crc_d;
    end
  end

  crcfr_skid u_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept & emit),
    .item_i  (res),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .item_o  (out_item)
  );

  assign m_axis_tdata_o = out_item.data;
  assign m_axis_tlast_o = out_item.last;
  assign m_axis_tuser_o = out_item.good;

`ifndef SYNTH
  a_verdict_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tlast_o) |-> (m_axis_tdata_o == '0))
    else $error("verdict item with nonzero data");

  a_payload_not_good: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tlast_o) |-> !m_axis_tuser_o)
    else $error("payload item flagged good");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q != PosIdle && pos_q != PosLength) |-> (pos_q <= pos_crc_hi + 9'd2))
    else $error("byte position past stop byte");

  a_stop_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pos_q == pos_crc_hi + 9'd2 && pos_q != PosIdle && pos_q != PosLength)
      |=> (pos_q == PosIdle))
    else $error("parser did not return to idle after stop byte");
`endif

endmodule

`default_nettype wire

>>> rtl/crcfr_skid.sv
// Two-entry output skid buffer: result register plus one spare entry.
`default_nettype none

module crcfr_skid (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire crcfr_pkg::out_item_t item_i,
  output logic                  ready_o,
  output logic                  valid_o,
  input  wire                   ready_i,
  output crcfr_pkg::out_item_t  item_o
);
  import crcfr_pkg::*;

  logic      out_valid_q, out_valid_d;
  logic      sk_valid_q, sk_valid_d;
  out_item_t out_item_q, out_item_d;
  out_item_t sk_item_q, sk_item_d;
  logic      push;

  assign ready_o = ~sk_valid_q;
  assign valid_o = out_valid_q;
  assign item_o  = out_item_q;
  assign push    = push_i & ~sk_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    sk_valid_d  = sk_valid_q;
    out_item_d  = out_item_q;
    sk_item_d   = sk_item_q;
    if (ready_i || !out_valid_q) begin
      if (sk_valid_q) begin
        out_valid_d = 1'b1;
        out_item_d  = sk_item_q;
        sk_valid_d  = 1'b0;
      end else begin
        out_valid_d = push;
        out_item_d  = item_i;
      end
    end else if (push) begin
      sk_valid_d = 1'b1;
      sk_item_d  = item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sk_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      sk_valid_q  <= sk_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    sk_item_q  <= sk_item_d;
  end

`ifndef SYNTH
  // spare entry only fills behind a stalled result
  a_spare_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sk_valid_q |-> out_valid_q)
    else $error("skid spare valid without output valid");

  a_stall_holds_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sk_valid_q && out_valid_q && !ready_i) |=> (sk_valid_q && $stable(sk_item_q)))
    else $error("spare entry lost during stall");
`endif

endmodule

`default_nettype wire
